// ----- design/slpg_pkg.sv -----
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants for the side-key long-press gesture block.
// ----------------------------------------------------------------------------
package slpg_pkg;

    localparam int unsigned NUM_KEYS   = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LPM_W      = 16;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic REG_LONG_PRESS_MS    = 1'b0;
    localparam logic REG_GESTURES_ENABLED = 1'b1;

    localparam logic [LPM_W-1:0] LONG_PRESS_MS_RESET = 16'd500;

    typedef struct packed {
        logic [1:0]        press_edges;
        logic [1:0]        release_edges;
        logic [TIME_W-1:0] now_ms;
        logic              in_book;
        logic              nav_swapped;
    } slpg_in_t;

    typedef struct packed {
        logic [1:0] emit_press;
        logic [1:0] emit_release;
        logic [1:0] hide_press;
        logic [1:0] hide_release;
        logic [1:0] hide_held;
        logic       back_pulse;
        logic       select_pulse;
    } slpg_out_t;

    // per-key result of one frame
    typedef struct packed {
        logic emit_press;
        logic hide_press;
        logic hide_release;
        logic hide_held;
        logic long_hit;
    } slpg_key_res_t;

endpackage

// ----- design/slpg_in_reg.sv -----
// ----------------------------------------------------------------------------
// slpg_in_reg
// Input register stage: captures one frame and holds it until the core takes it.
// ----------------------------------------------------------------------------
module slpg_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slpg_pkg::slpg_in_t s_data,
    input  logic              take,
    output logic              q_valid,
    output slpg_pkg::slpg_in_t q_data
);

    logic               valid_reg;
    slpg_pkg::slpg_in_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || take;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ----- design/slpg_key.sv -----
// ----------------------------------------------------------------------------
// slpg_key
// One side key: contact state, hold timer compare and per-frame edge masks.
// ----------------------------------------------------------------------------
module slpg_key (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           enable,
    input  logic                           press,
    input  logic                           release_edge,
    input  logic [slpg_pkg::TIME_W-1:0]    now_ms,
    input  logic                           in_book,
    input  logic [slpg_pkg::LPM_W-1:0]     long_press_ms,
    output slpg_pkg::slpg_key_res_t        res
);

    logic                        down_reg, down_next;
    logic                        parked_reg, parked_next;
    logic                        consumed_reg, consumed_next;
    logic [slpg_pkg::TIME_W-1:0] time_reg, time_next;

    logic                        down_p, parked_p, consumed_p, consumed_q;
    logic                        active, held_long;
    logic [slpg_pkg::TIME_W-1:0] elapsed;

    always_comb begin
        // a press restarts the contact
        down_p     = press ? 1'b1    : down_reg;
        parked_p   = press ? !in_book : parked_reg;
        consumed_p = press ? 1'b0    : consumed_reg;
        time_next  = press ? now_ms  : time_reg;

        elapsed   = now_ms - time_next;
        held_long = elapsed >= {{(slpg_pkg::TIME_W-slpg_pkg::LPM_W){1'b0}}, long_press_ms};
        active    = down_p && parked_p;

        res.hide_press = enable && active;
        res.hide_held  = enable && active;
        res.long_hit   = enable && active && !consumed_p && !in_book && held_long;
        consumed_q     = consumed_p || (active && (in_book || held_long));

        res.hide_release = enable && release_edge && parked_p;
        res.emit_press   = enable && release_edge && parked_p && !consumed_q;

        // a release ends the contact
        down_next     = release_edge ? 1'b0 : down_p;
        parked_next   = release_edge ? 1'b0 : parked_p;
        consumed_next = release_edge ? 1'b0 : consumed_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg     <= 1'b0;
            parked_reg   <= 1'b0;
            consumed_reg <= 1'b0;
        end else if (advance && enable) begin
            down_reg     <= down_next;
            parked_reg   <= parked_next;
            consumed_reg <= consumed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && enable) begin
            time_reg <= time_next;
        end
    end

endmodule

// ----- design/side_key_long_press_gesture.sv -----
// ----------------------------------------------------------------------------
// side_key_long_press_gesture
// Short/long press detector for two side keys with book-aware edge hiding.
// ----------------------------------------------------------------------------
// Usage:
//   One item on the s_ channel is one input frame: press and release edges of
//   the upper (bit 0) and lower (bit 1) key, a millisecond timestamp, the
//   in-book flag and the swapped-navigation flag. Every item yields exactly
//   one result item on the m_ channel: synthesized presses, deferred
//   releases, hide masks and the one-frame back/select pulses.
//   Pipeline: input register, then result register, which drives m_.
//   Throughput: one item per cycle while m_ready stays high; the per-key
//   logic (one 32-bit subtract and compare) sits between the two registers,
//   so key state is updated for every item as it moves while gestures are
//   enabled. Receiver stall: the result register holds; the input register
//   still takes one more item, then s_ready drops until m_ready returns.
//   Reset (aresetn low, synchronous): both stages empty, key contact flags and
//   the pending release mask clear, long_press_ms = 500, gestures enabled.
//   Configuration: cfg_wr_en writes register cfg_addr (0 long_press_ms,
//   1 gestures_enabled) from cfg_wdata; write only while idle.
// ----------------------------------------------------------------------------
module side_key_long_press_gesture (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  slpg_pkg::slpg_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output slpg_pkg::slpg_out_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [slpg_pkg::LPM_W-1:0] long_press_ms_reg;
    logic                       gestures_en_reg;
    logic [1:0]                 pending_reg, pending_next;
    logic                       out_valid_reg;
    slpg_pkg::slpg_out_t        out_reg, out_next;

    logic                       q_valid;
    slpg_pkg::slpg_in_t         q_data;
    logic                       advance;
    slpg_pkg::slpg_key_res_t    key_res [slpg_pkg::NUM_KEYS];

    // move the held frame into the result register when that one is free
    assign advance = q_valid && (!out_valid_reg || m_ready);

    slpg_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (advance),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    // one contact tracker per side key
    for (genvar k = 0; k < slpg_pkg::NUM_KEYS; k++) begin : g_key
        slpg_key u_key (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .advance       (advance),
            .enable        (gestures_en_reg),
            .press         (q_data.press_edges[k]),
            .release_edge  (q_data.release_edges[k]),
            .now_ms        (q_data.now_ms),
            .in_book       (q_data.in_book),
            .long_press_ms (long_press_ms_reg),
            .res           (key_res[k])
        );
    end

    // combine the two keys; role follows the swap flag
    always_comb begin
        out_next.emit_press   = {key_res[1].emit_press,   key_res[0].emit_press};
        out_next.emit_release = pending_reg;
        out_next.hide_press   = {key_res[1].hide_press,   key_res[0].hide_press};
        out_next.hide_release = {key_res[1].hide_release, key_res[0].hide_release};
        out_next.hide_held    = {key_res[1].hide_held,    key_res[0].hide_held};
        out_next.back_pulse   = q_data.nav_swapped ? key_res[1].long_hit
                                                   : key_res[0].long_hit;
        out_next.select_pulse = q_data.nav_swapped ? key_res[0].long_hit
                                                   : key_res[1].long_hit;
        // a synthesized press publishes its release on the next frame
        pending_next          = out_next.emit_press;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_ms_reg <= slpg_pkg::LONG_PRESS_MS_RESET;
            gestures_en_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                slpg_pkg::REG_LONG_PRESS_MS: begin
                    long_press_ms_reg <= cfg_wdata[slpg_pkg::LPM_W-1:0];
                end
                slpg_pkg::REG_GESTURES_ENABLED: begin
                    gestures_en_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // pending releases and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 2'b00;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                pending_reg <= pending_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // the deferred release mask always mirrors the presses just published
    a_pending_tracks_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (pending_reg == m_data.emit_press))
        else $error("pending release mask out of step with emitted presses");

    // a synthesized press only comes from a hidden raw release
    a_emit_needs_hidden_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.emit_press & ~m_data.hide_release) == 2'b00))
        else $error("synthesized press without a hidden release");

    // a long-hold pulse only fires on a key whose held level is hidden
    a_pulse_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.back_pulse || m_data.select_pulse))
            |-> (m_data.hide_held != 2'b00))
        else $error("long-hold pulse without a hidden held key");

    // with gestures off, only deferred releases leave the block
    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !gestures_en_reg) |=> (m_data.emit_press == 2'b00
            && m_data.hide_held == 2'b00 && !m_data.back_pulse && !m_data.select_pulse))
        else $error("gesture output while gestures are disabled");

endmodule

// ----- verif/side_key_long_press_gesture_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// side_key_long_press_gesture_tb
// Self-checking bench for the side-key short/long press detector. A queue of
// key frames feeds a valid/ready driver with random gaps. Every accepted frame
// runs through a cycle-free predictor of the gesture machine, and the
// predicted result waits in order until the monitor (itself stalling at
// random) compares the block's result field by field. A directed opening
// covers short and long presses, both key roles, book entry, pass-through,
// timestamp wrap and the disabled machine. Random phases then sweep the hold
// threshold and the enable bit.
// ----------------------------------------------------------------------------
module side_key_long_press_gesture_tb;

    // per-key edge masks
    localparam logic [1:0] NONE  = 2'b00;
    localparam logic [1:0] UPPER = 2'b01;
    localparam logic [1:0] LOWER = 2'b10;
    localparam logic [1:0] BOTH  = 2'b11;

    // cycles without any handshake before the run is declared hung
    localparam int unsigned STALL_LIMIT = 5000;
    // pipeline depth plus margin, used before config writes and at the end
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned MAX_REPORTS = 10;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    slpg_pkg::slpg_in_t              s_data = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    slpg_pkg::slpg_out_t             m_data;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_addr = slpg_pkg::REG_LONG_PRESS_MS;
    logic [slpg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    side_key_long_press_gesture dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the block's key tracking and registers
    // ------------------------------------------------------------------
    logic [slpg_pkg::LPM_W-1:0]  hold_limit_ms = slpg_pkg::LONG_PRESS_MS_RESET;
    logic                        gestures_on = 1'b1;
    logic [1:0]                  held_keys = '0;
    logic [1:0]                  parked_keys = '0;
    logic [1:0]                  spent_keys = '0;
    logic [slpg_pkg::TIME_W-1:0] press_stamp [slpg_pkg::NUM_KEYS] = '{default: '0};
    logic [1:0]                  deferred_rel = '0;

    slpg_pkg::slpg_in_t  frame_q [$];     // frames waiting for the driver
    slpg_pkg::slpg_out_t gesture_q [$];   // predicted results, oldest first
    slpg_pkg::slpg_out_t gesture_want;

    int unsigned miss_cnt = 0;
    int unsigned result_idx = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    logic        no_idle = 1'b0;

    // stimulus-side view of the keys and the clock
    logic [1:0]                  stim_down = '0;
    logic                        stim_book = 1'b0;
    logic                        stim_swap = 1'b0;
    logic [slpg_pkg::TIME_W-1:0] stim_ms = '0;

    // Advance the gesture machine by one frame and return its result.
    function automatic slpg_pkg::slpg_out_t predict_gesture(input slpg_pkg::slpg_in_t f);
        slpg_pkg::slpg_out_t         o;
        logic [slpg_pkg::TIME_W-1:0] held_for;
        int                          back_key;
        o = '0;
        back_key = f.nav_swapped ? 1 : 0;
        // the release deferred from last frame goes out now, enabled or not
        o.emit_release = deferred_rel;
        deferred_rel = '0;
        if (gestures_on) begin
            for (int k = 0; k < slpg_pkg::NUM_KEYS; k++) begin
                // a press (re)starts the contact; outside a book it is parked
                if (f.press_edges[k]) begin
                    held_keys[k] = 1'b1;
                    press_stamp[k] = f.now_ms;
                    spent_keys[k] = 1'b0;
                    parked_keys[k] = !f.in_book;
                end
                // parked contact: hide it, then test the hold
                if (held_keys[k] && parked_keys[k]) begin
                    o.hide_press[k] = 1'b1;
                    o.hide_held[k] = 1'b1;
                    if (!spent_keys[k]) begin
                        held_for = f.now_ms - press_stamp[k];
                        if (f.in_book) begin
                            // book opened mid-hold: swallow the contact
                            spent_keys[k] = 1'b1;
                        end else if (held_for >= {{(slpg_pkg::TIME_W-slpg_pkg::LPM_W){1'b0}},
                                                  hold_limit_ms}) begin
                            spent_keys[k] = 1'b1;
                            if (k == back_key) begin
                                o.back_pulse = 1'b1;
                            end else begin
                                o.select_pulse = 1'b1;
                            end
                        end
                    end
                end
                // release last, so press and release in one frame work
                if (f.release_edges[k]) begin
                    if (parked_keys[k]) begin
                        if (!spent_keys[k]) begin
                            o.emit_press[k] = 1'b1;
                            deferred_rel[k] = 1'b1;
                        end
                        o.hide_release[k] = 1'b1;
                    end
                    held_keys[k] = 1'b0;
                    parked_keys[k] = 1'b0;
                    spent_keys[k] = 1'b0;
                end
            end
        end
        return o;
    endfunction

    // Mostly back-to-back, some short pauses, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string fname, input logic [1:0] want_v,
                               input logic [1:0] got_v);
        if (got_v !== want_v) begin
            miss_cnt++;
            if (miss_cnt <= MAX_REPORTS) begin
                $display("result %0d: %s expected %b, got %b",
                         result_idx, fname, want_v, got_v);
            end
        end
    endtask

    task automatic push_frame(input logic [1:0] pr, input logic [1:0] rl,
                              input logic [slpg_pkg::TIME_W-1:0] t, input logic book,
                              input logic swap);
        slpg_pkg::slpg_in_t f;
        f.press_edges = pr;
        f.release_edges = rl;
        f.now_ms = t;
        f.in_book = book;
        f.nav_swapped = swap;
        frame_q.push_back(f);
    endtask

    // Build one random frame. Most frames follow the keys' real up/down
    // history with a timestamp stepping around the threshold; the rest are
    // noise (double presses, stray releases, same-frame press and release).
    task automatic gen_frame();
        logic [1:0]  pr;
        logic [1:0]  rl;
        int unsigned thr;
        thr = 32'(hold_limit_ms);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: stim_ms += $urandom_range(0, 3);
            7, 8, 9, 10, 11:     stim_ms += $urandom_range(0, thr / 4 + 1);
            12, 13, 14, 15:      stim_ms += thr - 1 + $urandom_range(0, 2);
            16, 17, 18:          stim_ms += $urandom_range(0, thr);
            default:             stim_ms += $urandom();
        endcase
        if ($urandom_range(0, 99) < 85) begin
            pr = NONE;
            rl = NONE;
            for (int k = 0; k < slpg_pkg::NUM_KEYS; k++) begin
                if (stim_down[k]) begin
                    rl[k] = ($urandom_range(0, 2) == 0);
                end else if ($urandom_range(0, 19) == 0) begin
                    pr[k] = 1'b1;
                    rl[k] = 1'b1;
                end else begin
                    pr[k] = ($urandom_range(0, 2) == 0);
                end
            end
        end else begin
            pr = 2'($urandom_range(0, 3));
            rl = 2'($urandom_range(0, 3));
        end
        stim_down = (stim_down | pr) & ~rl;
        if ($urandom_range(0, 11) == 0) begin
            stim_book = ~stim_book;
        end
        if ($urandom_range(0, 15) == 0) begin
            stim_swap = ~stim_swap;
        end
        push_frame(pr, rl, stim_ms, stim_book, stim_swap);
    endtask

    // Wait until every frame is sent and every result is back, then let the
    // pipeline settle. Sample at the falling edge to stay clear of updates.
    task automatic wait_idle();
        while (frame_q.size() != 0 || s_valid || gesture_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr,
                             input logic [slpg_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        if (addr == slpg_pkg::REG_LONG_PRESS_MS) begin
            hold_limit_ms = val[slpg_pkg::LPM_W-1:0];
        end else begin
            gestures_on = val[0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next frame once the slot is free and the gap
    // has run out; hold valid and payload until the item is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                // predict at acceptance, so state follows the accepted order
                gesture_q.push_back(predict_gesture(s_data));
                send_gap = no_idle ? 0 : pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && frame_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= frame_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap != 0) begin
                        send_gap--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results with random back-pressure and compare each one
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (gesture_q.size() == 0) begin
                    miss_cnt++;
                    if (miss_cnt <= MAX_REPORTS) begin
                        $display("result %0d arrived with nothing expected", result_idx);
                    end
                end else begin
                    gesture_want = gesture_q.pop_front();
                    check_field("emit_press", gesture_want.emit_press, m_data.emit_press);
                    check_field("emit_release", gesture_want.emit_release,
                                m_data.emit_release);
                    check_field("hide_press", gesture_want.hide_press, m_data.hide_press);
                    check_field("hide_release", gesture_want.hide_release,
                                m_data.hide_release);
                    check_field("hide_held", gesture_want.hide_held, m_data.hide_held);
                    check_field("back_pulse", {1'b0, gesture_want.back_pulse},
                                {1'b0, m_data.back_pulse});
                    check_field("select_pulse", {1'b0, gesture_want.select_pulse},
                                {1'b0, m_data.select_pulse});
                end
                result_idx++;
            end
            // stall the receiver now and then
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog: any handshake or config write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at reset settings: 500 ms, gestures on.
        // short press outside a book: hidden, re-emitted, release deferred
        push_frame(UPPER, NONE, 32'd1000, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'd1200, 1'b0, 1'b0);
        push_frame(NONE, UPPER, 32'd1300, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'd1301, 1'b0, 1'b0);
        // long hold on the lower key, one short of and then at the threshold
        push_frame(LOWER, NONE, 32'd2000, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'd2499, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'd2500, 1'b0, 1'b0);
        push_frame(NONE, LOWER, 32'd2600, 1'b0, 1'b0);
        // swapped roles: upper becomes select, lower becomes back
        push_frame(UPPER, NONE, 32'd3000, 1'b0, 1'b1);
        push_frame(NONE, NONE, 32'd3500, 1'b0, 1'b1);
        push_frame(NONE, UPPER, 32'd3600, 1'b0, 1'b1);
        // threshold reached on the release frame itself
        push_frame(LOWER, NONE, 32'd3700, 1'b0, 1'b1);
        push_frame(NONE, LOWER, 32'd4300, 1'b0, 1'b1);
        // inside a book both keys pass through
        push_frame(BOTH, NONE, 32'd5000, 1'b1, 1'b0);
        push_frame(NONE, BOTH, 32'd5100, 1'b1, 1'b0);
        // parked contact swallowed when the book opens mid-hold
        push_frame(UPPER, NONE, 32'd6000, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'd6010, 1'b1, 1'b0);
        push_frame(NONE, UPPER, 32'd6020, 1'b1, 1'b0);
        // stray release, then press and release of both keys in one frame
        push_frame(NONE, LOWER, 32'd6030, 1'b0, 1'b0);
        push_frame(BOTH, BOTH, 32'd6040, 1'b0, 1'b1);
        // re-press restarts the timer; the hold spans the timestamp wrap
        push_frame(UPPER, NONE, 32'hFFFF_FF00, 1'b0, 1'b0);
        push_frame(UPPER, NONE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_frame(NONE, NONE, 32'h0000_01F2, 1'b0, 1'b0);
        push_frame(NONE, UPPER, 32'h0000_01F3, 1'b0, 1'b0);
        // leave a deferred release behind for the disabled machine
        push_frame(LOWER, LOWER, 32'h0000_0300, 1'b0, 1'b0);
        wait_idle();

        // Machine off: the pending release still drains, edges pass.
        write_reg(slpg_pkg::REG_GESTURES_ENABLED, 16'd0);
        push_frame(NONE, NONE, 32'h0000_0400, 1'b0, 1'b0);
        push_frame(UPPER, NONE, 32'h0000_0500, 1'b0, 1'b0);
        push_frame(NONE, UPPER, 32'h0000_0A00, 1'b0, 1'b1);
        push_frame(BOTH, BOTH, 32'h0000_0B00, 1'b1, 1'b1);
        wait_idle();

        // Random phases over the threshold range and the enable bit.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       write_reg(slpg_pkg::REG_LONG_PRESS_MS, 16'd1);
                1:       write_reg(slpg_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
                2:       write_reg(slpg_pkg::REG_LONG_PRESS_MS,
                                   slpg_pkg::LONG_PRESS_MS_RESET);
                6:       write_reg(slpg_pkg::REG_LONG_PRESS_MS,
                                   16'($urandom_range(1, 65535)));
                default: write_reg(slpg_pkg::REG_LONG_PRESS_MS,
                                   16'($urandom_range(1, 2000)));
            endcase
            write_reg(slpg_pkg::REG_GESTURES_ENABLED,
                      (ph == 3) ? 16'd0 : 16'(($urandom_range(0, 5) != 0)));
            // run one phase without any idling on either side
            no_idle = (ph == 5);
            stim_ms = $urandom();
            for (int n = 0; n < 92; n++) begin
                gen_frame();
            end
            wait_idle();
        end

        if (miss_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
